/* rtl/lng_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lng_pkg;
    localparam int DepthW = 9;
    localparam int DelayDepth = 1 << DepthW;
    localparam logic [16:0] UnityGain = 17'd65536;
    localparam logic [2:0] CfgEnable = 3'd0;
    localparam logic [2:0] CfgThresh = 3'd1;
    localparam logic [2:0] CfgRange  = 3'd2;
    localparam logic [2:0] CfgGainK  = 3'd3;
    localparam logic [2:0] CfgHold   = 3'd4;
    localparam logic [2:0] CfgDelay  = 3'd5;
    localparam logic [2:0] CfgHpf    = 3'd6;
    localparam logic [2:0] CfgDetK   = 3'd7;
    typedef enum logic [3:0] {
        t_idle, t_clear, t_rd, t_hp0, t_hp1, t_hp2, t_det0, t_det1,
        t_gain0, t_gain1, t_scale0, t_scale1, t_out
    } t_state;
endpackage
`default_nettype wire

/* rtl/lookahead_noise_gate.sv */
`timescale 1ns / 1ps
`default_nettype none
// Lookahead noise gate: one stereo word in, one word out. A side chain
// (mono mean, high-pass biquad, peak follower, hysteresis gate with hold,
// one-pole gain smoother) sets a gain that is applied to audio delayed
// through a 512-entry ring RAM. With the gate enabled a word steps through
// the sequencer states for the biquad, follower, smoother and scaling steps
// before the output register loads in the output state, and the input
// reopens the cycle after. With the gate disabled a word goes from idle to
// the output state and passes undelayed at unity gain. A finished word
// waits in the output register while one more word is taken and processed;
// that word then holds in the last state until the output drains. After
// reset a clearing pass zeroes every ring entry; no word is accepted during
// it. Configuration is taken at any time but must only change while idle.
module lookahead_noise_gate (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [47:0] s_axis_tdata,  // left_sample, right_sample
    input  wire [1:0]  s_axis_tuser,  // active_channels
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [71:0] m_axis_tdata, // left_out, right_out, applied_gain, zero pad
    output logic       m_axis_tuser,  // gate_open
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire [2:0]  i_cfg_index,
    input  wire [59:0] i_cfg_data
);
    import lng_pkg::*;

    logic        r_en;
    logic [47:0] r_thr, r_gk, r_dk;
    logic [16:0] r_rng;
    logic [19:0] r_hold;
    logic [8:0]  r_dly;
    logic [59:0] r_hpf;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0; r_thr <= '0; r_rng <= '0; r_gk <= '0;
            r_hold <= '0; r_dly <= '0; r_hpf <= '0; r_dk <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgEnable: r_en   <= i_cfg_data[0];
                CfgThresh: r_thr  <= i_cfg_data[47:0];
                CfgRange:  r_rng  <= i_cfg_data[16:0];
                CfgGainK:  r_gk   <= i_cfg_data[47:0];
                CfgHold:   r_hold <= i_cfg_data[19:0];
                CfgDelay:  r_dly  <= i_cfg_data[8:0];
                CfgHpf:    r_hpf  <= i_cfg_data;
                CfgDetK:   r_dk   <= i_cfg_data[47:0];
                default: ;
            endcase
        end
    end

    // ring RAM, one write port with a write enable per channel half and
    // one registered read port
    logic [47:0] ram [DelayDepth];
    logic [47:0] r_rdata, w_wdata;
    logic        w_we_l, w_we_r;
    logic [DepthW-1:0] w_waddr, w_raddr;
    always_ff @(posedge i_clk) begin
        if (w_we_l) ram[w_waddr][47:24] <= w_wdata[47:24];
        if (w_we_r) ram[w_waddr][23:0] <= w_wdata[23:0];
        r_rdata <= ram[w_raddr];
    end

    t_state r_st, n_st;
    logic [DepthW-1:0] r_wi, r_cnt;
    logic signed [23:0] r_l, r_r;
    logic        r_two;
    logic signed [24:0] r_mono;
    logic signed [31:0] r_z0, r_z1;
    logic signed [23:0] r_y;
    logic [23:0] r_lvl, r_mag;
    logic        r_open;
    logic [19:0] r_hc;
    logic [16:0] r_cg, r_tg;
    logic signed [47:0] r_pa, r_pb;
    logic [47:0] r_entry;
    logic        r_ovalid;
    logic [71:0] r_od;
    logic        r_ou;

    logic signed [19:0] w_b0, w_a1, w_a2;
    assign w_b0 = r_hpf[59:40];
    assign w_a1 = r_hpf[39:20];
    assign w_a2 = r_hpf[19:0];
    logic [16:0] w_rng;
    assign w_rng = (r_rng > UnityGain) ? UnityGain : r_rng;

    function automatic logic signed [63:0] rsh(input logic signed [63:0] v,
                                                input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7fffff;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    // clamp the lookahead to below the ring depth
    logic [DepthW-1:0] w_d;
    assign w_d = (32'(r_dly) > DelayDepth - 1) ? DepthW'(DelayDepth - 1) : DepthW'(r_dly);
    assign w_raddr = r_wi - w_d;

    assign s_axis_tready = (r_st == t_idle);
    wire w_acc = s_axis_tvalid && s_axis_tready;
    wire w_two = s_axis_tuser > 2'd1;
    // load the output register once the previous word has left
    wire w_emit = (r_st == t_out) && (!r_ovalid || m_axis_tready);

    // mono mean: sum halved, truncating toward zero
    logic signed [25:0] w_sum, w_sum_adj;
    logic signed [24:0] w_mono;
    assign w_sum = w_two ? (26'(signed'(s_axis_tdata[23:0]))
                            + 26'(signed'(s_axis_tdata[47:24])))
                         : (26'(signed'(s_axis_tdata[23:0])) <<< 1);
    assign w_sum_adj = w_sum + (w_sum[25] ? 26'sd1 : 26'sd0);
    assign w_mono = w_sum_adj[25:1];

    // products, one per sequencer step
    logic signed [44:0] w_prod_b0;
    logic signed [43:0] w_prod_a1, w_prod_a2;
    assign w_prod_b0 = w_b0 * r_mono;
    assign w_prod_a1 = w_a1 * r_y;
    assign w_prod_a2 = w_a2 * r_y;

    logic [23:0] w_det_k;
    logic signed [24:0] w_det_diff;
    logic signed [49:0] w_det_prod;
    assign w_det_k = (r_mag > r_lvl) ? r_dk[47:24] : r_dk[23:0];
    assign w_det_diff = $signed({1'b0, r_lvl}) - $signed({1'b0, r_mag});
    assign w_det_prod = w_det_diff * $signed({1'b0, w_det_k});

    logic [23:0] w_gain_k;
    logic signed [17:0] w_gain_diff;
    logic signed [42:0] w_gain_prod;
    assign w_gain_k = (r_tg > r_cg) ? r_gk[47:24] : r_gk[23:0];
    assign w_gain_diff = $signed({1'b0, r_cg}) - $signed({1'b0, r_tg});
    assign w_gain_prod = w_gain_diff * $signed({1'b0, w_gain_k});

    logic signed [41:0] w_scale_l, w_scale_r;
    assign w_scale_l = $signed(r_entry[47:24]) * $signed({1'b0, r_cg});
    assign w_scale_r = $signed(r_entry[23:0]) * $signed({1'b0, r_cg});

    logic [63:0] w_lvl_sum, w_cg_sum;
    logic [23:0] w_lvl_n;
    assign w_lvl_sum = 64'(r_mag) + rsh(64'(r_pa), 24);
    assign w_lvl_n = w_lvl_sum[23:0];
    assign w_cg_sum = 64'(r_tg) + rsh(64'(r_pa), 24);

    // hysteresis with hold
    logic        w_open_n;
    logic [19:0] w_hc_n;
    always_comb begin
        w_open_n = r_open;
        w_hc_n = r_hc;
        if (w_lvl_n > r_thr[47:24]) begin
            w_open_n = 1'b1;
            w_hc_n = r_hold;
        end else if (w_lvl_n < r_thr[23:0]) begin
            if (r_hc != '0) w_hc_n = r_hc - 20'd1;
            else w_open_n = 1'b0;
        end
    end

    always_comb begin
        w_we_l = 1'b0; w_we_r = 1'b0; w_waddr = r_wi;
        // left in bits 47:24 of the entry, right below
        w_wdata = {s_axis_tdata[23:0], s_axis_tdata[47:24]};
        n_st = r_st;
        case (r_st)
            t_clear: begin
                w_we_l = 1'b1; w_we_r = 1'b1; w_waddr = r_cnt; w_wdata = '0;
                if (r_cnt == DepthW'(DelayDepth - 1)) n_st = t_idle;
            end
            t_idle: begin
                // a mono word leaves the right half of the entry alone
                w_we_l = w_acc;
                w_we_r = w_acc && w_two;
                if (w_acc) n_st = r_en ? t_rd : t_out;
            end
            t_rd:     n_st = t_hp0;
            t_hp0:    n_st = t_hp1;
            t_hp1:    n_st = t_hp2;
            t_hp2:    n_st = t_det0;
            t_det0:   n_st = t_det1;
            t_det1:   n_st = t_gain0;
            t_gain0:  n_st = t_gain1;
            t_gain1:  n_st = t_scale0;
            t_scale0: n_st = t_scale1;
            t_scale1: n_st = t_out;
            t_out:    if (w_emit) n_st = t_idle;
            default:  n_st = t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_clear; r_cnt <= '0; r_wi <= '0; r_z0 <= '0; r_z1 <= '0;
            r_lvl <= '0; r_open <= 1'b0; r_hc <= '0; r_cg <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_emit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                t_clear: r_cnt <= r_cnt + DepthW'(1);
                t_idle: if (w_acc) begin
                    r_l <= s_axis_tdata[23:0];
                    r_r <= s_axis_tdata[47:24];
                    r_two <= w_two;
                    r_mono <= w_mono;
                end
                t_rd: r_pa <= 48'(w_prod_b0);
                t_hp0: begin
                    r_entry <= r_rdata;
                    r_y <= sat24(rsh(64'(r_pa), 18) + 64'(r_z0));
                end
                t_hp1: r_pb <= 48'(w_prod_a1);
                t_hp2: begin
                    r_z0 <= sat32(rsh(-(64'(r_pa) <<< 1) - 64'(r_pb), 18) + 64'(r_z1));
                    r_z1 <= sat32(rsh(64'(r_pa) - 64'(w_prod_a2), 18));
                    if (r_y == 24'sh800000) r_mag <= 24'h7fffff;
                    else r_mag <= r_y < 0 ? 24'(-r_y) : r_y;
                end
                t_det0: r_pa <= 48'(w_det_prod);
                t_det1: begin
                    r_lvl <= w_lvl_n;
                    r_open <= w_open_n;
                    r_hc <= w_hc_n;
                    r_tg <= w_open_n ? UnityGain : w_rng;
                end
                t_gain0: r_pa <= 48'(w_gain_prod);
                t_gain1: r_cg <= w_cg_sum[16:0];
                t_scale0: begin
                    r_pa <= 48'(w_scale_l);
                    r_pb <= 48'(w_scale_r);
                end
                t_scale1: begin
                    r_l <= sat24(64'(r_pa) >>> 16);
                    r_r <= r_two ? sat24(64'(r_pb) >>> 16) : '0;
                end
                t_out: if (w_emit) begin
                    r_wi <= r_wi + DepthW'(1);
                    if (r_en) begin
                        r_od <= {7'd0, r_cg, r_r, r_l};
                        r_ou <= r_open;
                    end else begin
                        r_od <= {7'd0, UnityGain, r_two ? r_r : 24'h0, r_l};
                        r_ou <= 1'b1;
                        r_open <= 1'b1; r_cg <= UnityGain;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_od;
    assign m_axis_tuser = r_ou;
endmodule
`default_nettype wire
